// ===== hdl/sblc_pkg.sv =====
// sblc_pkg: shared types, constants and tables of the spectral bin loudness compressor
// no dependencies; imported by every sblc module and by the top level
package sblc_pkg;

  localparam int LAT_PWR  = 5;
  localparam int LAT_LOG  = 20;
  localparam int LAT_GAIN = 21;
  localparam int LAT_SCL  = 2;
  localparam int FRAC_BITS = 16;

  localparam logic [17:0] DB_PER_LOG2 = 18'd197283;
  localparam logic [21:0] EXP_PER_DB  = 22'd2786596;
  localparam logic [23:0] GAIN_MAX    = 24'hFFFFFF;
  localparam logic [23:0] GAIN_ONE    = 24'd65536;
  localparam logic [3:0]  FFT_LOG2_MIN = 4'd1;
  localparam logic [3:0]  FFT_LOG2_MAX = 4'd11;
  localparam logic [3:0]  FFT_LOG2_RST = 4'd8;
  localparam logic [29:0] FLOOR_RST    = 30'd107;

  typedef enum logic [3:0] {
    CFG_FFT_SIZE_LOG2 = 4'd0,
    CFG_POWER_FLOOR   = 4'd1
  } cfg_idx_t;

  typedef struct packed {
    logic valid;
    logic below;
  } pwr_ctl_t;

  // 2^(2^-i) in Q.30
  function automatic logic [30:0] pow2_frac(input int i);
    logic [30:0] t;
    case (i)
      1:  t = 31'd1518500250;
      2:  t = 31'd1276901417;
      3:  t = 31'd1170923762;
      4:  t = 31'd1121280436;
      5:  t = 31'd1097253708;
      6:  t = 31'd1085434106;
      7:  t = 31'd1079572136;
      8:  t = 31'd1076653034;
      9:  t = 31'd1075196442;
      10: t = 31'd1074468887;
      11: t = 31'd1074105294;
      12: t = 31'd1073923544;
      13: t = 31'd1073832680;
      14: t = 31'd1073787251;
      15: t = 31'd1073764537;
      16: t = 31'd1073753180;
      default: t = 31'd1073741824;
    endcase
    return t;
  endfunction

endpackage

// ===== hdl/sblc_power.sv =====
// sblc_power: bin power (re^2+im^2) >> fft_size_log2 (clamped to 1..11) and floor compare, five stages
// depends on sblc_pkg
module sblc_power import sblc_pkg::*; #(
  parameter int CB = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [CB-1:0] re,
  input  logic signed [CB-1:0] im,
  input  logic [3:0]           fft_log2,
  input  logic [29:0]          power_floor,
  output pwr_ctl_t             ctl,
  output logic [2*CB-1:0]      pwr
);
  localparam int HB = (CB + 1) / 2;
  localparam int LB = CB - HB;
  localparam int PW = 2 * CB;

  logic            v1_r, v2_r, v3_r, v4_r;
  logic [CB-1:0]   mr_r, mi_r, mr_nxt, mi_nxt;
  logic [2*HB-1:0] rll_r, ill_r;
  logic [HB+LB-1:0] rlh_r, ilh_r;
  logic [2*LB-1:0] rhh_r, ihh_r;
  logic [PW-1:0]   sqr_r, sqi_r, sqr_nxt, sqi_nxt;
  logic [PW-1:0]   p4_r, p4_nxt, pwr_r;
  logic [3:0]      shc;
  pwr_ctl_t        ctl_r;

  assign mr_nxt = re[CB-1] ? (~$unsigned(re) + CB'(1)) : $unsigned(re);
  assign mi_nxt = im[CB-1] ? (~$unsigned(im) + CB'(1)) : $unsigned(im);

  assign sqr_nxt = (PW'(rhh_r) << (2 * HB)) + (PW'(rlh_r) << (HB + 1)) + PW'(rll_r);
  assign sqi_nxt = (PW'(ihh_r) << (2 * HB)) + (PW'(ilh_r) << (HB + 1)) + PW'(ill_r);

  always_comb begin
    if (fft_log2 < FFT_LOG2_MIN) shc = FFT_LOG2_MIN;
    else if (fft_log2 > FFT_LOG2_MAX) shc = FFT_LOG2_MAX;
    else shc = fft_log2;
  end

  assign p4_nxt = (sqr_r + sqi_r) >> shc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ctl_r <= '0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      ctl_r.valid <= v4_r;
      ctl_r.below <= (p4_r <= PW'(power_floor));
    end
  end

  always_ff @(posedge clk) begin
    mr_r  <= mr_nxt;
    mi_r  <= mi_nxt;
    rll_r <= (2*HB)'(mr_r[HB-1:0]) * (2*HB)'(mr_r[HB-1:0]);
    rlh_r <= (HB+LB)'(mr_r[HB-1:0]) * (HB+LB)'(mr_r[CB-1:HB]);
    rhh_r <= (2*LB)'(mr_r[CB-1:HB]) * (2*LB)'(mr_r[CB-1:HB]);
    ill_r <= (2*HB)'(mi_r[HB-1:0]) * (2*HB)'(mi_r[HB-1:0]);
    ilh_r <= (HB+LB)'(mi_r[HB-1:0]) * (HB+LB)'(mi_r[CB-1:HB]);
    ihh_r <= (2*LB)'(mi_r[CB-1:HB]) * (2*LB)'(mi_r[CB-1:HB]);
    sqr_r <= sqr_nxt;
    sqi_r <= sqi_nxt;
    p4_r  <= p4_nxt;
    pwr_r <= p4_r;
  end

  assign ctl = ctl_r;
  assign pwr = pwr_r;

endmodule

// ===== hdl/sblc_log.sv =====
// sblc_log: level in dB (Q8.8) from power, normalize then 16 squaring stages
// depends on sblc_pkg
module sblc_log import sblc_pkg::*; #(
  parameter int PW = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pwr_ctl_t           in_ctl,
  input  logic [PW-1:0]      pwr,
  output pwr_ctl_t           out_ctl,
  output logic signed [15:0] level
);
  localparam int EW = $clog2(PW);

  pwr_ctl_t      ctla_r, ctll_r, ctlo_r;
  logic [EW-1:0] e_nxt, ea_r;
  logic [PW-1:0] pa_r, xs;
  logic [30:0]   xb_nxt;
  logic signed [15:0] lqe;
  logic signed [31:0] lq;
  logic signed [50:0] prod_r, lv;
  logic signed [15:0] level_r;

  pwr_ctl_t              ctl_s [0:FRAC_BITS];
  logic [30:0]           x_s   [0:FRAC_BITS];
  logic [FRAC_BITS-1:0]  fr_s  [0:FRAC_BITS];
  logic [EW-1:0]         e_s   [0:FRAC_BITS];

  // leading one
  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < PW; i++) begin
      if (pwr[i]) e_nxt = EW'(i);
    end
  end

  always_comb begin
    if (ea_r >= EW'(30)) xs = pa_r >> (ea_r - EW'(30));
    else xs = pa_r << (EW'(30) - ea_r);
    xb_nxt = xs[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctla_r <= '0;
      ctl_s[0] <= '0;
    end else begin
      ctla_r <= in_ctl;
      ctl_s[0] <= ctla_r;
    end
  end

  always_ff @(posedge clk) begin
    ea_r    <= e_nxt;
    pa_r    <= pwr;
    x_s[0]  <= xb_nxt;
    fr_s[0] <= '0;
    e_s[0]  <= ea_r;
  end

  // one fraction bit per stage by squaring
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] t;
    assign sq = 62'(x_s[k]) * 62'(x_s[k]);
    assign t  = sq[61:30];

    always_ff @(posedge clk) begin
      if (!rst_n) ctl_s[k+1] <= '0;
      else ctl_s[k+1] <= ctl_s[k];
    end

    always_ff @(posedge clk) begin
      x_s[k+1]  <= t[31] ? t[31:1] : t[30:0];
      fr_s[k+1] <= {fr_s[k][FRAC_BITS-2:0], t[31]};
      e_s[k+1]  <= e_s[k];
    end
  end

  assign lqe = $signed(16'(e_s[FRAC_BITS])) - 16'sd30;
  assign lq  = {lqe, fr_s[FRAC_BITS]};
  assign lv  = (prod_r + 51'sd8388608) >>> 24;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctll_r <= '0;
      ctlo_r <= '0;
    end else begin
      ctll_r <= ctl_s[FRAC_BITS];
      ctlo_r <= ctll_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 51'(lq) * 51'($signed({1'b0, DB_PER_LOG2}));
    if (lv > 51'sd32767) level_r <= 16'sd32767;
    else if (lv < -51'sd32768) level_r <= -16'sd32768;
    else level_r <= lv[15:0];
  end

  assign out_ctl = ctlo_r;
  assign level   = level_r;

endmodule

// ===== hdl/sblc_gain.sv =====
// sblc_gain: target level, exponent and 2^x gain in Q8.16 over 16 mantissa stages
// depends on sblc_pkg
module sblc_gain import sblc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  pwr_ctl_t           in_ctl,
  input  logic signed [15:0] level,
  input  logic signed [15:0] slope,
  input  logic signed [15:0] icpt,
  output pwr_ctl_t           out_ctl,
  output logic [23:0]        gain
);
  typedef struct packed {
    pwr_ctl_t    c;
    logic        big;
    logic        tiny;
    logic [5:0]  sh;
    logic [15:0] f;
  } gctl_t;

  pwr_ctl_t c1_r, c2_r, c3_r, co_r;
  logic signed [31:0] sl_r;
  logic signed [15:0] lv1_r, ic1_r;
  logic signed [33:0] tw;
  logic signed [23:0] diff_r;
  logic signed [47:0] pe_r, exw, nw, sw;
  gctl_t g_nxt;
  gctl_t g_s [0:FRAC_BITS];
  logic [31:0] m_s [0:FRAC_BITS];
  logic [40:0] rnd, gw;
  logic [23:0] gain_r;

  assign tw = ((34'(sl_r) + 34'sd2048) >>> 12) + 34'(ic1_r) - 34'(lv1_r);

  always_comb begin
    exw = (pe_r + 48'sd32768) >>> 16;
    nw  = exw >>> 16;
    sw  = 48'sd14 - nw;
    g_nxt.c    = c3_r;
    g_nxt.big  = (exw >= 48'sd524288);
    g_nxt.tiny = (nw < -48'sd26);
    g_nxt.sh   = sw[5:0];
    g_nxt.f    = exw[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      g_s[0] <= '0;
    end else begin
      c1_r <= in_ctl;
      c2_r <= c1_r;
      c3_r <= c2_r;
      g_s[0] <= g_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sl_r   <= 32'(slope) * 32'(level);
    lv1_r  <= level;
    ic1_r  <= icpt;
    diff_r <= tw[23:0];
    pe_r   <= 48'(diff_r) * 48'($signed({1'b0, EXP_PER_DB}));
    m_s[0] <= 32'd1 << 30;
  end

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_exp
    logic [62:0] pm;
    assign pm = 63'(m_s[k]) * 63'(pow2_frac(k + 1)) + (63'd1 << 29);

    always_ff @(posedge clk) begin
      if (!rst_n) g_s[k+1] <= '0;
      else g_s[k+1] <= g_s[k];
    end

    always_ff @(posedge clk) begin
      m_s[k+1] <= g_s[k].f[FRAC_BITS-1-k] ? pm[61:30] : m_s[k];
    end
  end

  assign rnd = 41'(m_s[FRAC_BITS]) + (41'd1 << (g_s[FRAC_BITS].sh - 6'd1));
  assign gw  = rnd >> g_s[FRAC_BITS].sh;

  always_ff @(posedge clk) begin
    if (!rst_n) co_r <= '0;
    else co_r <= g_s[FRAC_BITS].c;
  end

  always_ff @(posedge clk) begin
    if (g_s[FRAC_BITS].c.below) gain_r <= GAIN_ONE;
    else if (g_s[FRAC_BITS].big) gain_r <= GAIN_MAX;
    else if (g_s[FRAC_BITS].tiny) gain_r <= '0;
    else if (gw > 41'(GAIN_MAX)) gain_r <= GAIN_MAX;
    else gain_r <= gw[23:0];
  end

  assign out_ctl = co_r;
  assign gain    = gain_r;

endmodule

// ===== hdl/sblc_scale.sv =====
// sblc_scale: scales four components by the gain with rounding and saturation
// depends on sblc_pkg
module sblc_scale import sblc_pkg::*; #(
  parameter int CB = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pwr_ctl_t             in_ctl,
  input  logic [23:0]          gain,
  input  logic signed [CB-1:0] comp [4],
  output pwr_ctl_t             out_ctl,
  output logic [23:0]          out_gain,
  output logic signed [CB-1:0] out_comp [4]
);
  localparam int HB = (CB + 1) / 2;
  localparam int LB = CB - HB;
  localparam int W  = CB + 25;

  pwr_ctl_t c1_r, co_r;
  logic [23:0] g1_r, go_r;
  logic        neg_r [4];
  logic [HB+23:0] plo_r [4];
  logic [LB+23:0] phi_r [4];
  logic signed [CB-1:0] oc_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      co_r <= '0;
    end else begin
      c1_r <= in_ctl;
      co_r <= c1_r;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_comp
    logic [CB-1:0] mag;
    logic [W-1:0]  full, q, lim;
    logic [CB-1:0] qs;

    assign mag  = comp[c][CB-1] ? (~$unsigned(comp[c]) + CB'(1)) : $unsigned(comp[c]);
    assign full = (W'(phi_r[c]) << HB) + W'(plo_r[c]) + W'(16'h8000);
    assign lim  = neg_r[c] ? (W'(1) << (CB - 1)) : ((W'(1) << (CB - 1)) - W'(1));
    assign q    = full >> 16;
    assign qs   = (q > lim) ? lim[CB-1:0] : q[CB-1:0];

    always_ff @(posedge clk) begin
      neg_r[c] <= comp[c][CB-1];
      plo_r[c] <= (HB+24)'(mag[HB-1:0]) * (HB+24)'(gain);
      phi_r[c] <= (LB+24)'(mag[CB-1:HB]) * (LB+24)'(gain);
      oc_r[c]  <= neg_r[c] ? $signed(~qs + CB'(1)) : $signed(qs);
    end
  end

  always_ff @(posedge clk) begin
    g1_r <= gain;
    go_r <= g1_r;
  end

  assign out_ctl  = co_r;
  assign out_gain = go_r;
  assign out_comp = oc_r;

endmodule

// ===== hdl/spectral_bin_loudness_compressor_top.sv =====
// spectral_bin_loudness_compressor_top: per-bin-pair dynamic range compression
// depends on sblc_pkg, sblc_power, sblc_log, sblc_gain, sblc_scale
//
//  channel | ports                                   | beat taken when
//  --------+-----------------------------------------+--------------------------
//  input   | start, busy, in_*                       | start high, busy low
//  result  | out_valid, out_*                        | every cycle out_valid high
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_wdata | cfg_valid and cfg_ready
//
// one bin pair enters per cycle; busy stays low and every beat is taken
// result follows the power, log2, gain and scale stages; most of the depth is
// the 16-stage log2 squaring chain and the 16-stage exponent mantissa chain
// rst_n is synchronous; it clears the valid bits and loads the register resets
// the receiver cannot stall, so the pipeline only ever advances
module spectral_bin_loudness_compressor_top import sblc_pkg::*; #(
  parameter int COMPONENT_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COMPONENT_BITS-1:0] in_bin_real,
  input  logic signed [COMPONENT_BITS-1:0] in_bin_imag,
  input  logic signed [COMPONENT_BITS-1:0] in_mirror_real,
  input  logic signed [COMPONENT_BITS-1:0] in_mirror_imag,
  input  logic signed [15:0]               in_slope,
  input  logic signed [15:0]               in_intercept_db,
  output logic                             out_valid,
  output logic signed [COMPONENT_BITS-1:0] out_bin_real,
  output logic signed [COMPONENT_BITS-1:0] out_bin_imag,
  output logic signed [COMPONENT_BITS-1:0] out_mirror_real,
  output logic signed [COMPONENT_BITS-1:0] out_mirror_imag,
  output logic [23:0]                      out_gain,
  output logic                             out_below_floor,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [3:0]                       cfg_index,
  input  logic [29:0]                      cfg_wdata
);
  localparam int CB = COMPONENT_BITS;
  localparam int PW = 2 * CB;
  localparam int D_COMP = LAT_PWR + LAT_LOG + LAT_GAIN;
  localparam int D_CRV  = LAT_PWR + LAT_LOG;
  localparam int LAT_ALL = D_COMP + LAT_SCL;

  logic [3:0]  fft_log2_r;
  logic [29:0] floor_r;
  logic        accept;

  pwr_ctl_t pw_ctl, lg_ctl, gn_ctl, sc_ctl;
  logic [PW-1:0]      pwr;
  logic signed [15:0] level;
  logic [23:0]        gain;

  logic signed [CB-1:0] cd_r [0:D_COMP-1][4];
  logic signed [15:0]   sd_r [0:D_CRV-1];
  logic signed [15:0]   id_r [0:D_CRV-1];
  logic signed [CB-1:0] sc_comp [4];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fft_log2_r <= FFT_LOG2_RST;
      floor_r    <= FLOOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FFT_SIZE_LOG2) fft_log2_r <= cfg_wdata[3:0];
      else if (cfg_index == CFG_POWER_FLOOR) floor_r <= cfg_wdata;
    end
  end

  // payload delay lines that meet the computed gain and level
  always_ff @(posedge clk) begin
    cd_r[0][0] <= in_bin_real;
    cd_r[0][1] <= in_bin_imag;
    cd_r[0][2] <= in_mirror_real;
    cd_r[0][3] <= in_mirror_imag;
    for (int k = 1; k < D_COMP; k++) cd_r[k] <= cd_r[k-1];
    sd_r[0] <= in_slope;
    id_r[0] <= in_intercept_db;
    for (int k = 1; k < D_CRV; k++) begin
      sd_r[k] <= sd_r[k-1];
      id_r[k] <= id_r[k-1];
    end
  end

  sblc_power #(.CB(CB)) u_power (
    .clk, .rst_n,
    .in_valid    (accept),
    .re          (in_bin_real),
    .im          (in_bin_imag),
    .fft_log2    (fft_log2_r),
    .power_floor (floor_r),
    .ctl         (pw_ctl),
    .pwr         (pwr)
  );

  sblc_log #(.PW(PW)) u_log (
    .clk, .rst_n,
    .in_ctl  (pw_ctl),
    .pwr     (pwr),
    .out_ctl (lg_ctl),
    .level   (level)
  );

  sblc_gain u_gain (
    .clk, .rst_n,
    .in_ctl  (lg_ctl),
    .level   (level),
    .slope   (sd_r[D_CRV-1]),
    .icpt    (id_r[D_CRV-1]),
    .out_ctl (gn_ctl),
    .gain    (gain)
  );

  sblc_scale #(.CB(CB)) u_scale (
    .clk, .rst_n,
    .in_ctl   (gn_ctl),
    .gain     (gain),
    .comp     (cd_r[D_COMP-1]),
    .out_ctl  (sc_ctl),
    .out_gain (out_gain),
    .out_comp (sc_comp)
  );

  assign out_valid       = sc_ctl.valid;
  assign out_below_floor = sc_ctl.below;
  assign out_bin_real    = sc_comp[0];
  assign out_bin_imag    = sc_comp[1];
  assign out_mirror_real = sc_comp[2];
  assign out_mirror_imag = sc_comp[3];

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT_ALL))
    else $error("result beat without matching input beat");

  a_below: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_below_floor) |-> (out_gain == GAIN_ONE))
    else $error("below floor beat with gain other than one");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_gain == '0) |->
      (out_bin_real == '0 && out_bin_imag == '0 &&
       out_mirror_real == '0 && out_mirror_imag == '0))
    else $error("zero gain beat with nonzero component");

endmodule
